// ===== rtl/pulse_period_smoothing_filter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse period smoothing filter
// Defining NO_ASSERTIONS removes every assertion from the design.
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_SMOOTHING_FILTER_CORE_DEFINES_SVH
`define PULSE_PERIOD_SMOOTHING_FILTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PPSF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppsf assertion failed");

// Next-cycle implication.
`define PPSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppsf assertion failed");

`else

`define PPSF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PPSF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ppsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsf_pkg
// Types and constants shared by the pulse period smoothing filter modules.
// ----------------------------------------------------------------------------
package ppsf_pkg;

   localparam int STAMP_W    = 32;
   localparam int AVGOUT_W   = 40;
   localparam int COUNT_W    = 16;
   localparam int AVGCNT_W   = 8;
   localparam int INTTIME_W  = 16;
   localparam int OPCODE_W   = 2;
   localparam int WEIGHT_W   = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   // Step counter of the shared unit; holds the longest operation, the integrating divide.
   localparam int CNT_W      = 7;
   // Scale factor of the integrating weight and its product width with int_time.
   localparam int WEIGHT_SCALE = 500;
   localparam int WSCALED_W    = 25;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [OPCODE_W-1:0] OP_EDGE    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_TIME  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_MUL,
      ST_AVG_DIV,
      ST_INT_PICK,
      ST_WGT_DIV,
      ST_INT_MUL,
      ST_INT_DIV,
      ST_OUTPUT
   } state_type;

   typedef enum logic {
      MD_MUL,
      MD_DIV
   } mode_type;

   typedef struct packed {
      logic             start;
      mode_type         mode;
      logic [CNT_W-1:0] steps;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef struct packed {
      logic idle;
      logic load;
   } seq_sts_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  period_us;
      logic [AVGOUT_W-1:0] average_q8;
      logic [AVGOUT_W-1:0] integral_q8;
      logic [COUNT_W-1:0]  sample_count;
   } result_type;

endpackage

// ===== rtl/ppsf_if.sv =====
// ----------------------------------------------------------------------------
// ppsf_req_if / ppsf_rsp_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface ppsf_req_if;
   import ppsf_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [STAMP_W-1:0]  stamp_us;

   modport source (output valid, output opcode, output stamp_us, input ready);
   modport sink   (input valid, input opcode, input stamp_us, output ready);
endinterface

interface ppsf_rsp_if;
   import ppsf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STAMP_W-1:0]  period_us;
   logic [AVGOUT_W-1:0] average_q8;
   logic [AVGOUT_W-1:0] integral_q8;
   logic [COUNT_W-1:0]  sample_count;

   modport source (output valid, output period_us, output average_q8,
                   output integral_q8, output sample_count, input ready);
   modport sink   (input valid, input period_us, input average_q8,
                   input integral_q8, input sample_count, output ready);
endinterface

// ===== rtl/pulse_period_smoothing_filter_core.sv =====
// ----------------------------------------------------------------------------
// pulse_period_smoothing_filter_core
// Pulse period measurement with a running and an integrating average.
// ----------------------------------------------------------------------------
// Each edge transaction on the request channel carries a free-running
// microsecond timestamp; an edge that has a predecessor produces one result
// transaction with the wrapped period, the running average, the integrating
// average (both unsigned fixed point with FRACTION_BITS fraction bits) and
// the saturating sample count. Restart, clear and unknown opcodes, and the
// first edge after reset, clear or restart, give no result. An edge that
// gives a result occupies the block while the single shared shift-add /
// restoring divide unit works, one bit per cycle, through up to five
// operations per edge: the running average multiply and divide, the weight
// divide, and the integrating multiply and divide; fewer operations run
// when an average is taken over directly. The request channel is ready only
// while the sequencer is idle; a finished result sits in the output
// register, so the next request is taken while it waits to be read.
// Configuration writes (register 0 avg_count, register 1 int_time) are
// registered and are meant for times when no transaction is in progress.
// ----------------------------------------------------------------------------
`include "pulse_period_smoothing_filter_core_defines.svh"

module pulse_period_smoothing_filter_core #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   ppsf_req_if.sink                           req_chan,
   ppsf_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_en,
   input  logic [ppsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppsf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ppsf_pkg::*;

   localparam int NW = STAMP_W + FRACTION_BITS + WEIGHT_W;

   logic [AVGCNT_W-1:0]  avg_count_ff, avg_count_in;
   logic [INTTIME_W-1:0] int_time_ff, int_time_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff, result_in;

   seq_sts_type  seq_sts;
   result_type   seq_result;
   unit_ctl_type unit_ctl;
   unit_sts_type unit_sts;
   logic [NW-1:0] unit_opa;
   logic [NW-1:0] unit_ops;
   logic [NW-1:0] unit_res;
   logic          req_take;
   logic          out_free;

   // Requests are taken only while the sequencer is idle.
   assign req_chan.ready = seq_sts.idle;
   assign req_take       = req_chan.valid && seq_sts.idle;

   // The output register may be refilled in the cycle its transaction leaves.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Configuration registers.
   always_comb begin
      avg_count_in = avg_count_ff;
      int_time_in  = int_time_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_AVG_COUNT: avg_count_in = csr_wdata[AVGCNT_W-1:0];
            CSR_INT_TIME:  int_time_in  = csr_wdata[INTTIME_W-1:0];
            default:       avg_count_in = avg_count_ff;
         endcase
      end
   end

   // Result register.
   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (seq_sts.load) begin
         result_in    = seq_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff <= AVGCNT_W'(5);
         int_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         avg_count_ff <= avg_count_in;
         int_time_ff  <= int_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.period_us    = result_ff.period_us;
   assign rsp_chan.average_q8   = result_ff.average_q8;
   assign rsp_chan.integral_q8  = result_ff.integral_q8;
   assign rsp_chan.sample_count = result_ff.sample_count;

   ppsf_seq #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req_opcode (req_chan.opcode),
      .req_stamp  (req_chan.stamp_us),
      .avg_count  (avg_count_ff),
      .int_time   (int_time_ff),
      .out_free   (out_free),
      .unit_sts   (unit_sts),
      .unit_res   (unit_res),
      .unit_ctl   (unit_ctl),
      .unit_opa   (unit_opa),
      .unit_ops   (unit_ops),
      .seq_sts    (seq_sts),
      .result     (seq_result)
   );

   ppsf_muldiv #(
      .WIDTH (NW)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctl       (unit_ctl),
      .operand_a (unit_opa),
      .operand_s (unit_ops),
      .sts       (unit_sts),
      .result    (unit_res)
   );

   `PPSF_ASSERT_IMPLY(a_load_into_free, clock, reset, seq_sts.load, out_free)
   `PPSF_ASSERT_NEXT(a_load_shows, clock, reset, seq_sts.load, rsp_valid_ff)
   `PPSF_ASSERT_IMPLY(a_count_nonzero, clock, reset, rsp_valid_ff, result_ff.sample_count != '0)

endmodule

// ===== rtl/ppsf_muldiv.sv =====
// ----------------------------------------------------------------------------
// ppsf_muldiv
// Shared bit-serial multiplier and restoring divider built on one adder.
// ----------------------------------------------------------------------------
`include "pulse_period_smoothing_filter_core_defines.svh"

module ppsf_muldiv #(
   parameter int WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppsf_pkg::unit_ctl_type ctl,
   input  logic [WIDTH-1:0]      operand_a,
   input  logic [WIDTH-1:0]      operand_s,
   output ppsf_pkg::unit_sts_type sts,
   output logic [WIDTH-1:0]      result
);
   import ppsf_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sh_ff, sh_in;

   logic             is_div;
   logic             top_bit;
   logic [WIDTH:0]   x_val;
   logic [WIDTH:0]   y_val;
   logic [WIDTH+1:0] sum;
   logic             ge;

   // One adder serves both operations: add the multiplicand in a multiply
   // step, subtract the divisor in a divide step.
   always_comb begin
      is_div  = (mode_ff == MD_DIV);
      top_bit = sh_ff[WIDTH-1];
      if (is_div) begin
         x_val = {acc_ff, top_bit};
         y_val = {1'b0, a_ff};
      end else begin
         x_val = {1'b0, acc_ff[WIDTH-2:0], 1'b0};
         y_val = top_bit ? {1'b0, a_ff} : '0;
      end
      sum = {1'b0, x_val} + {1'b0, (is_div ? ~y_val : y_val)}
            + (WIDTH+2)'(is_div);
      ge  = sum[WIDTH+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         cnt_in  = ctl.steps;
         a_in    = operand_a;
         acc_in  = '0;
         sh_in   = operand_s;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (is_div) begin
            acc_in = ge ? sum[WIDTH-1:0] : x_val[WIDTH-1:0];
            sh_in  = {sh_ff[WIDTH-2:0], ge};
         end else begin
            acc_in = sum[WIDTH-1:0];
            sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= MD_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   // The quotient builds up in the shift register, the product in the accumulator.
   assign result   = is_div ? sh_ff : acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

   `PPSF_ASSERT_IMPLY(a_start_when_free, clock, reset, ctl.start, !busy_ff && !done_ff)
   `PPSF_ASSERT_IMPLY(a_busy_has_steps, clock, reset, busy_ff, cnt_ff != '0)
   `PPSF_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff && !busy_ff)

endmodule

// ===== rtl/ppsf_seq.sv =====
// ----------------------------------------------------------------------------
// ppsf_seq
// Filter state and the sequencer that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
module ppsf_seq #(
   parameter int FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_take,
   input  logic [ppsf_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [ppsf_pkg::STAMP_W-1:0]      req_stamp,
   input  logic [ppsf_pkg::AVGCNT_W-1:0]     avg_count,
   input  logic [ppsf_pkg::INTTIME_W-1:0]    int_time,
   input  logic                              out_free,
   input  ppsf_pkg::unit_sts_type            unit_sts,
   input  logic [64+FRACTION_BITS-1:0]       unit_res,
   output ppsf_pkg::unit_ctl_type            unit_ctl,
   output logic [64+FRACTION_BITS-1:0]       unit_opa,
   output logic [64+FRACTION_BITS-1:0]       unit_ops,
   output ppsf_pkg::seq_sts_type             seq_sts,
   output ppsf_pkg::result_type              result
);
   import ppsf_pkg::*;

   localparam int AW   = STAMP_W + FRACTION_BITS;
   localparam int NW   = AW + WEIGHT_W;
   localparam int WN_W = WSCALED_W + FRACTION_BITS;

   state_type             state_ff, state_in;
   logic [STAMP_W-1:0]    last_stamp_ff, last_stamp_in;
   logic                  have_last_ff, have_last_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [AW-1:0]         ravg_ff, ravg_in;
   logic [AW-1:0]         integ_ff, integ_in;
   logic [AW-1:0]         lwb_ff, lwb_in;
   logic [STAMP_W-1:0]    period_ff, period_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;

   logic [STAMP_W-1:0]    period_new;
   logic                  avg_bypass;
   logic [AVGCNT_W-1:0]   mult;
   logic [AW-1:0]         p_val;
   logic [WN_W-1:0]       wnum;
   logic [COUNT_W-1:0]    count_next;
   logic                  unit_op;
   logic [AVGOUT_W+AW-1:0] ravg_wide;
   logic [AVGOUT_W+AW-1:0] integ_wide;

   always_comb begin
      period_new = req_stamp - last_stamp_ff;
      avg_bypass = (count_ff == '0) || (avg_count == '0);
      mult       = (COUNT_W'(avg_count) < count_ff) ? avg_count : count_ff[AVGCNT_W-1:0];
      p_val      = AW'(period_ff) << FRACTION_BITS;
      wnum       = (WN_W'(int_time) * WN_W'(WEIGHT_SCALE)) << FRACTION_BITS;
      count_next = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_opcode == OP_EDGE) && have_last_ff) begin
               state_in = avg_bypass ? ST_INT_PICK : ST_AVG_MUL;
            end
         end
         ST_AVG_MUL: if (unit_sts.done) state_in = ST_AVG_DIV;
         ST_AVG_DIV: if (unit_sts.done) state_in = ST_INT_PICK;
         ST_INT_PICK: begin
            priority if (integ_ff == '0) state_in = ST_OUTPUT;
            else if (lwb_ff == '0)       state_in = ST_INT_MUL;
            else                         state_in = ST_WGT_DIV;
         end
         ST_WGT_DIV: if (unit_sts.done) state_in = ST_INT_MUL;
         ST_INT_MUL: if (unit_sts.done) state_in = ST_INT_DIV;
         ST_INT_DIV: if (unit_sts.done) state_in = ST_OUTPUT;
         ST_OUTPUT:  if (out_free) state_in = ST_IDLE;
      endcase
   end

   // Outputs: unit commands and status toward the top level. A unit operation
   // starts in the first cycle of its state, when the unit is neither busy nor
   // reporting completion.
   always_comb begin
      unit_op        = 1'b0;
      unit_ctl.mode  = MD_MUL;
      unit_ctl.steps = '0;
      unit_opa       = '0;
      unit_ops       = '0;
      unique case (state_ff)
         ST_AVG_MUL: begin
            unit_op        = 1'b1;
            unit_ctl.mode  = MD_MUL;
            unit_ctl.steps = CNT_W'(AVGCNT_W);
            unit_opa       = NW'(ravg_ff);
            unit_ops       = NW'(mult) << (NW - AVGCNT_W);
         end
         ST_AVG_DIV: begin
            unit_op        = 1'b1;
            unit_ctl.mode  = MD_DIV;
            unit_ctl.steps = CNT_W'(AW + AVGCNT_W);
            unit_opa       = NW'(mult) + NW'(1);
            unit_ops       = (unit_res + NW'(p_val)) << (NW - AW - AVGCNT_W);
         end
         ST_WGT_DIV: begin
            unit_op        = 1'b1;
            unit_ctl.mode  = MD_DIV;
            unit_ctl.steps = CNT_W'(WN_W);
            unit_opa       = NW'(lwb_ff);
            unit_ops       = NW'(wnum) << (NW - WN_W);
         end
         ST_INT_MUL: begin
            unit_op        = 1'b1;
            unit_ctl.mode  = MD_MUL;
            unit_ctl.steps = CNT_W'(WEIGHT_W);
            unit_opa       = NW'(integ_ff);
            unit_ops       = NW'(weight_ff) << AW;
         end
         ST_INT_DIV: begin
            unit_op        = 1'b1;
            unit_ctl.mode  = MD_DIV;
            unit_ctl.steps = CNT_W'(NW);
            unit_opa       = NW'(weight_ff) + NW'(1);
            unit_ops       = unit_res + NW'(ravg_ff);
         end
         default: begin
            unit_op = 1'b0;
         end
      endcase
      unit_ctl.start = unit_op && !unit_sts.busy && !unit_sts.done;
      seq_sts.idle   = (state_ff == ST_IDLE);
      seq_sts.load   = (state_ff == ST_OUTPUT) && out_free;
   end

   // Filter state updates.
   always_comb begin
      last_stamp_in = last_stamp_ff;
      have_last_in  = have_last_ff;
      count_in      = count_ff;
      ravg_in       = ravg_ff;
      integ_in      = integ_ff;
      lwb_in        = lwb_ff;
      period_in     = period_ff;
      weight_in     = weight_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_opcode)
                  OP_EDGE: begin
                     last_stamp_in = req_stamp;
                     have_last_in  = 1'b1;
                     if (have_last_ff) begin
                        period_in = period_new;
                        if (avg_bypass) begin
                           ravg_in = AW'(period_new) << FRACTION_BITS;
                        end
                     end
                  end
                  OP_RESTART: begin
                     have_last_in = 1'b0;
                     count_in     = COUNT_W'(1);
                  end
                  OP_CLEAR: begin
                     last_stamp_in = '0;
                     have_last_in  = 1'b0;
                     count_in      = '0;
                     ravg_in       = '0;
                     integ_in      = '0;
                     lwb_in        = '0;
                  end
                  default: begin
                     have_last_in = have_last_ff;
                  end
               endcase
            end
         end
         ST_AVG_DIV: if (unit_sts.done) ravg_in = unit_res[AW-1:0];
         ST_INT_PICK: begin
            // A first integral takes the running average; a zero weight base
            // gives the largest weight.
            priority if (integ_ff == '0) integ_in = ravg_ff;
            else if (lwb_ff == '0)       weight_in = '1;
            else                         weight_in = weight_ff;
         end
         ST_WGT_DIV: begin
            if (unit_sts.done) begin
               weight_in = (|unit_res[NW-1:WEIGHT_W]) ? '1 : unit_res[WEIGHT_W-1:0];
            end
         end
         ST_INT_DIV: if (unit_sts.done) integ_in = unit_res[AW-1:0];
         ST_OUTPUT: begin
            if (out_free) begin
               lwb_in   = ravg_ff;
               count_in = count_next;
            end
         end
         default: begin
            weight_in = weight_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_stamp_ff <= '0;
         have_last_ff  <= 1'b0;
         count_ff      <= '0;
         ravg_ff       <= '0;
         integ_ff      <= '0;
         lwb_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         last_stamp_ff <= last_stamp_in;
         have_last_ff  <= have_last_in;
         count_ff      <= count_in;
         ravg_ff       <= ravg_in;
         integ_ff      <= integ_in;
         lwb_ff        <= lwb_in;
      end
      period_ff <= period_in;
      weight_ff <= weight_in;
   end

   // The averages are cut or padded to the 40-bit result fields.
   always_comb begin
      ravg_wide           = {{AVGOUT_W{1'b0}}, ravg_ff};
      integ_wide          = {{AVGOUT_W{1'b0}}, integ_ff};
      result.period_us    = period_ff;
      result.average_q8   = ravg_wide[AVGOUT_W-1:0];
      result.integral_q8  = integ_wide[AVGOUT_W-1:0];
      result.sample_count = count_next;
   end

endmodule
